@@ rtl/positional_list_insert_delete_defines.svh @@
// assertion macros for the positional list block
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds at every sampled edge
`define PLID_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("plid: check failed");

// same-cycle implication
`define PLID_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("plid: check failed");

// next-cycle implication
`define PLID_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("plid: check failed");

`else

`define PLID_ASSERT(lbl, clk_s, rst_s, prop)
`define PLID_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PLID_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ rtl/plid_pkg.sv @@
package plid_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned STAT_W = 2;

  // slot numbers cover the largest supported capacity (256) plus zero
  localparam int unsigned IDX_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t            op;
    logic [IDX_W-1:0]    pos;      // one-based target position
    logic [IDX_W-1:0]    end_pos;  // last occupied position after the update
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

@@ rtl/plid_if.sv @@
interface plid_in_if;
  import plid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [POS_W-1:0]          position;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface plid_out_if;
  import plid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  read_value;
  logic signed [DATA_W-1:0]  head_value;
  logic signed [DATA_W-1:0]  tail_value;
  logic [LEN_W-1:0]          length;
  logic [STAT_W-1:0]         status;

  modport source (output valid, read_value, head_value, tail_value, length, status,
                  input ready);
  modport sink   (input valid, read_value, head_value, tail_value, length, status,
                  output ready);
endinterface

@@ rtl/plid_cell.sv @@
module plid_cell (
  input  logic                                clk,
  input  logic [plid_pkg::IDX_W-1:0]          slot,
  input  plid_pkg::cell_ctrl_t                ctrl,
  input  logic [plid_pkg::DATA_W-1:0]         prev_data,
  input  logic [plid_pkg::DATA_W-1:0]         next_data,
  output logic [plid_pkg::DATA_W-1:0]         data,
  output logic [plid_pkg::DATA_W-1:0]         rd_data,
  output logic [plid_pkg::DATA_W-1:0]         end_data
);
  import plid_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (slot == ctrl.pos);
  assign past_pos = (slot > ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (at_pos) begin
          data_nxt = ctrl.value;
        end else if (past_pos) begin
          data_nxt = prev_data;
        end
      end
      CELL_DELETE: begin
        if (at_pos || past_pos) begin
          data_nxt = next_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign rd_data  = at_pos ? data_r : '0;
  assign end_data = (slot == ctrl.end_pos) ? data_nxt : '0;

endmodule

@@ rtl/positional_list_insert_delete.sv @@
// channel   | dir | transfer when   | payload
// in_chan   | in  | valid && ready  | command, position, value
// out_chan  | out | valid && ready  | read_value, head_value, tail_value, length, status
//
// one item per cycle while out_chan is not stalled: every command finishes in the cycle it is accepted,
// the whole row of cells shifting together for insert and delete
// the result sits in the output register from the next cycle
// reset (rst_n low, synchronous) empties the list and drops any held result
// input is taken while the output register is empty or being drained,
// so a stall on out_chan backs up into in_chan after one held result

`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  plid_in_if.sink     in_chan,
  plid_out_if.source  out_chan
);
  import plid_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

  // list length
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // output register
  logic               out_valid_r;
  logic [DATA_W-1:0]  read_value_r;
  logic [DATA_W-1:0]  head_value_r;
  logic [DATA_W-1:0]  tail_value_r;
  logic [LEN_W-1:0]   length_r;
  status_t            status_r;

  logic               fire;
  status_t            status;
  cell_op_t           op;
  logic               rd_ok;
  logic [IDX_W-1:0]   pos_ext;
  logic [IDX_W-1:0]   cnt_ext;
  logic [IDX_W-1:0]   cnt_nxt_ext;
  cell_ctrl_t         ctrl;

  // row of cells
  logic [DATA_W-1:0]  cell_q   [CAPACITY];
  logic [DATA_W-1:0]  cell_rd  [CAPACITY];
  logic [DATA_W-1:0]  cell_end [CAPACITY];

  logic [DATA_W-1:0]  rd_bus;
  logic [DATA_W-1:0]  end_bus;
  logic [DATA_W-1:0]  head_nxt;

  // a new item goes in when the held result leaves or there is none
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign fire          = in_chan.valid && in_chan.ready;

  assign pos_ext = IDX_W'(in_chan.position);
  assign cnt_ext = IDX_W'(count_r);

  // command checks: empty before range for delete and read
  always_comb begin
    status    = ST_OK;
    op        = CELL_HOLD;
    rd_ok     = 1'b0;
    count_nxt = count_r;
    case (in_chan.command)
      CMD_INSERT: begin
        if (cnt_ext >= CAP_IDX) begin
          status = ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
          status = ST_RANGE;
        end else begin
          op        = CELL_INSERT;
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      CMD_DELETE: begin
        if (cnt_ext == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          op        = CELL_DELETE;
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      CMD_READ: begin
        if (cnt_ext == '0) begin
          status = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign cnt_nxt_ext = IDX_W'(count_nxt);

  // broadcast to the row; nothing moves without a transfer
  assign ctrl.op      = fire ? op : CELL_HOLD;
  assign ctrl.pos     = pos_ext;
  assign ctrl.end_pos = cnt_nxt_ext;
  assign ctrl.value   = in_chan.value;

  // each cell takes from its left neighbour on insert, its right on delete
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;

    if (k == 0) begin : g_first
      assign prev_d = in_chan.value;
    end else begin : g_mid_prev
      assign prev_d = cell_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_d = cell_q[k];
    end else begin : g_mid_next
      assign next_d = cell_q[k+1];
    end

    plid_cell u_cell (
      .clk       (clk),
      .slot      (IDX_W'(k + 1)),
      .ctrl      (ctrl),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[k]),
      .rd_data   (cell_rd[k]),
      .end_data  (cell_end[k])
    );
  end

  // at most one cell drives each bus, the rest give zero
  always_comb begin
    rd_bus  = '0;
    end_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus  = rd_bus  | cell_rd[k];
      end_bus = end_bus | cell_end[k];
    end
  end

  // head after the update: new value, the second entry moving up, or unchanged; zero if the list ends up empty
  always_comb begin
    head_nxt = cell_q[0];
    if (op == CELL_INSERT && pos_ext == IDX_W'(1)) begin
      head_nxt = in_chan.value;
    end else if (op == CELL_DELETE && pos_ext == IDX_W'(1)) begin
      head_nxt = cell_q[1];
    end
    if (cnt_nxt_ext == '0) begin
      head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (fire) begin
      read_value_r <= rd_ok ? rd_bus : '0;
      head_value_r <= head_nxt;
      tail_value_r <= end_bus;
      length_r     <= cnt_nxt_ext[LEN_W-1:0];
      status_r     <= status;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = read_value_r;
  assign out_chan.head_value = head_value_r;
  assign out_chan.tail_value = tail_value_r;
  assign out_chan.length     = length_r;
  assign out_chan.status     = status_r;

  // checks
  `PLID_ASSERT(a_count_bound, clk, rst_n, IDX_W'(count_r) <= CAP_IDX)
  `PLID_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_valid_r, in_chan.ready)
  `PLID_ASSERT_NXT(a_reject_keeps_count, clk, rst_n, rst_n && fire && status != ST_OK, count_r == $past(count_r))
  `PLID_ASSERT_NXT(a_insert_grows, clk, rst_n, rst_n && fire && op == CELL_INSERT, count_r == CNT_W'($past(count_r) + 1'b1))
  `PLID_ASSERT_IMP(a_empty_zero_ends, clk, rst_n, out_valid_r && length_r == '0, head_value_r == '0 && tail_value_r == '0)

endmodule
